// ===== rtl/core/nearest_neighbor_tour_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the nearest neighbor tour block
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_TOUR_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_TOUR_TOP_ASSERT_SVH

// same-cycle implication
`define NNT_ASSERT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define NNT_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== rtl/core/nnt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnt_pkg
// Field widths, types and command codes shared by the tour block files.
// ----------------------------------------------------------------------------
package nnt_pkg;

  localparam int IDX_W    = 6;
  localparam int WEIGHT_W = 32;
  localparam int COUNT_W  = 7;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [COUNT_W-1:0]  count_t;

  localparam count_t COUNT_RESET = 7'd64;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_RUN   = 1'b1;

endpackage

// ===== rtl/core/nnt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnt channel interfaces
// Request, result and node-count channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface nnt_req_if;
  logic             valid;
  logic             ready;
  logic             cmd;
  nnt_pkg::idx_t    from_index;
  nnt_pkg::idx_t    to_index;
  nnt_pkg::weight_t edge_weight;
  nnt_pkg::idx_t    start_node;

  modport source (output valid, cmd, from_index, to_index, edge_weight, start_node,
                  input ready);
  modport sink (input valid, cmd, from_index, to_index, edge_weight, start_node,
                output ready);
endinterface

interface nnt_rsp_if;
  logic             valid;
  logic             ready;
  nnt_pkg::idx_t    tour_from;
  nnt_pkg::idx_t    tour_to;
  nnt_pkg::weight_t tour_weight;
  logic             bad_start;
  logic             last;

  modport source (output valid, tour_from, tour_to, tour_weight, bad_start, last,
                  input ready);
  modport sink (input valid, tour_from, tour_to, tour_weight, bad_start, last,
                output ready);
endinterface

interface nnt_cfg_if;
  logic            valid;
  logic            ready;
  nnt_pkg::count_t node_count;

  modport source (output valid, node_count, input ready);
  modport sink (input valid, node_count, output ready);
endinterface

// ===== rtl/core/nearest_neighbor_tour_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_tour_top
// Greedy nearest neighbor tour over a weight matrix held in block memory.
// ----------------------------------------------------------------------------
// A write request stores one weight. A run request over n active nodes can be
// stalled by result back-pressure: each tour step reads the n weights of the
// current row through the single read port of the weight memory, one per
// cycle, then picks and emits. A bad start node gives one error result.
// Requests are taken only between runs; node_count writes are always taken.
// The weight memory is not cleared.
module nearest_neighbor_tour_top #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 32
) (
  input logic         clk,
  input logic         rst,
  nnt_req_if.sink     req,
  nnt_rsp_if.source   rsp,
  nnt_cfg_if.sink     cfg
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int DEPTH  = MAX_NODES * MAX_NODES;
  localparam int AW     = $clog2(DEPTH);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_DRAIN = 7'b0000100,
    S_EMIT  = 7'b0001000,
    S_CLOSE = 7'b0010000,
    S_FINAL = 7'b0100000,
    S_FAULT = 7'b1000000
  } state_t;

  state_t                 state;
  nnt_pkg::count_t        node_count;
  logic [MAX_NODES-1:0]   visited;
  logic [NODE_W-1:0]      cur;
  logic [NODE_W-1:0]      start_r;
  logic [NODE_W-1:0]      best;
  logic [WEIGHT_BITS-1:0] best_w;
  logic                   found;
  logic [CNT_W-1:0]       scan;
  logic [CNT_W-1:0]       rem;
  logic                   tag_v;
  logic [NODE_W-1:0]      tag_node;

  logic                   rsp_valid;
  nnt_pkg::idx_t          o_from;
  nnt_pkg::idx_t          o_to;
  nnt_pkg::weight_t       o_weight;
  logic                   o_bad;
  logic                   o_last;

  logic [WEIGHT_BITS-1:0] wmem [DEPTH];
  logic [WEIGHT_BITS-1:0] rd_data;

  logic [8:0]             nc_ext;
  logic [8:0]             n_clamp;
  logic [CNT_W-1:0]       act_n;
  logic                   start_ok;
  logic                   wr_ok;
  logic                   req_fire;
  logic                   out_free;
  logic                   mem_we;
  logic                   mem_re;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          row_base;
  logic [NODE_W-1:0]      scan_node;
  logic [NODE_W-1:0]      rd_col;
  logic [AW-1:0]          rd_addr;
  logic [NODE_W-1:0]      start_n;
  logic                   cmp_take;

  assign nc_ext   = 9'(node_count);
  assign n_clamp  = (nc_ext == 9'd0) ? 9'd1 :
                    ((nc_ext > 9'(MAX_NODES)) ? 9'(MAX_NODES) : nc_ext);
  assign act_n    = CNT_W'(n_clamp);
  assign start_ok = 9'(req.start_node) < n_clamp;
  assign wr_ok    = (9'(req.from_index) < 9'(MAX_NODES)) &&
                    (9'(req.to_index) < 9'(MAX_NODES));

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !rsp_valid || rsp.ready;

  assign start_n   = NODE_W'(req.start_node);
  assign scan_node = scan[NODE_W-1:0];
  assign mem_we    = req_fire && (req.cmd == nnt_pkg::CMD_WRITE) && wr_ok;
  assign wr_addr   = AW'(AW'(req.from_index) * AW'(MAX_NODES) + AW'(req.to_index));
  assign row_base  = AW'(AW'(cur) * AW'(MAX_NODES));
  assign rd_col    = (state == S_CLOSE) ? start_r : scan_node;
  assign rd_addr   = AW'(row_base + AW'(rd_col));
  assign mem_re    = (state == S_SCAN) || (state == S_CLOSE);
  assign cmp_take  = tag_v && (!found || (rd_data < best_w));

  assign rsp.valid       = rsp_valid;
  assign rsp.tour_from   = o_from;
  assign rsp.tour_to     = o_to;
  assign rsp.tour_weight = o_weight;
  assign rsp.bad_start   = o_bad;
  assign rsp.last        = o_last;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wmem[wr_addr] <= WEIGHT_BITS'(req.edge_weight);
    end
    if (mem_re) begin
      rd_data <= wmem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= nnt_pkg::COUNT_RESET;
      visited    <= '0;
      cur        <= '0;
      found      <= 1'b0;
      tag_v      <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        node_count <= cfg.node_count;
      end
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      tag_v <= 1'b0;
      // running minimum, one weight per cycle behind the read
      if (cmp_take) begin
        found  <= 1'b1;
        best   <= tag_node;
        best_w <= rd_data;
      end
      case (state)
        S_IDLE: begin
          if (req_fire && (req.cmd == nnt_pkg::CMD_RUN)) begin
            if (!start_ok) begin
              state <= S_FAULT;
            end else begin
              visited <= {{(MAX_NODES-1){1'b0}}, 1'b1} << start_n;
              cur     <= start_n;
              start_r <= start_n;
              rem     <= act_n - CNT_W'(1);
              scan    <= '0;
              found   <= 1'b0;
              state   <= (act_n == CNT_W'(1)) ? S_CLOSE : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          tag_v    <= !visited[scan_node];
          tag_node <= scan_node;
          scan     <= scan + CNT_W'(1);
          if (scan == act_n - CNT_W'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            rsp_valid     <= 1'b1;
            o_from        <= nnt_pkg::idx_t'(cur);
            o_to          <= nnt_pkg::idx_t'(best);
            o_weight      <= nnt_pkg::weight_t'(best_w);
            o_bad         <= 1'b0;
            o_last        <= 1'b0;
            visited[best] <= 1'b1;
            cur           <= best;
            rem           <= rem - CNT_W'(1);
            scan          <= '0;
            found         <= 1'b0;
            state         <= (rem == CNT_W'(1)) ? S_CLOSE : S_SCAN;
          end
        end
        S_CLOSE: begin
          state <= S_FINAL;
        end
        S_FINAL: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            o_from    <= nnt_pkg::idx_t'(cur);
            o_to      <= nnt_pkg::idx_t'(start_r);
            o_weight  <= nnt_pkg::weight_t'(rd_data);
            o_bad     <= 1'b0;
            o_last    <= 1'b1;
            cur       <= start_r;
            state     <= S_IDLE;
          end
        end
        S_FAULT: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            o_from    <= '0;
            o_to      <= '0;
            o_weight  <= '0;
            o_bad     <= 1'b1;
            o_last    <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "nearest_neighbor_tour_top_assert.svh"

  `NNT_ASSERT(a_emit_pick, state == S_EMIT, found && !visited[best], "pick is not an unvisited node")
  `NNT_ASSERT(a_scan_rem, state == S_SCAN, rem != '0, "scan started with no step left")
  `NNT_ASSERT_NEXT(a_close_home, (state == S_FINAL) && out_free, cur == start_r, "tour did not return to start")
  `NNT_ASSERT(a_tag_src, tag_v, $past(state == S_SCAN), "compare tag without a scan read")

endmodule

// ===== tb/sv/nearest_neighbor_tour_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_tour_top_tb
// Self-checking bench for the greedy tour block. An 8 by 8 block of the
// weight matrix is loaded first and every later run stays inside it, so runs
// read only written entries. Each accepted request goes through a local
// greedy tour predictor. Each emitted edge is checked field by field against
// the oldest predicted edge. Both sides idle at random, and the result side
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module nearest_neighbor_tour_top_tb;

  typedef nnt_pkg::idx_t    idx_t;
  typedef nnt_pkg::weight_t weight_t;
  typedef nnt_pkg::count_t  count_t;

  localparam int NODES_MAX     = 64;
  localparam int FILL_NODES    = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    logic    cmd;
    idx_t    from_index;
    idx_t    to_index;
    weight_t edge_weight;
    idx_t    start_node;
  } request_t;

  typedef struct packed {
    idx_t    tour_from;
    idx_t    tour_to;
    weight_t tour_weight;
    logic    bad_start;
    logic    last;
  } tour_edge_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nnt_req_if req_ch ();
  nnt_rsp_if rsp_ch ();
  nnt_cfg_if cfg_ch ();

  nearest_neighbor_tour_top #(
    .MAX_NODES   (NODES_MAX),
    .WEIGHT_BITS (nnt_pkg::WEIGHT_W)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  weight_t    edge_table [NODES_MAX][NODES_MAX];
  count_t     node_limit  = nnt_pkg::COUNT_RESET;
  tour_edge_t pending_edges [$];
  tour_edge_t due;
  int         mismatches  = 0;
  bit         steady      = 1'b0;
  int         holds_asked = 0;
  int         holds_done  = 0;

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic int active_nodes();
    if (node_limit == 0) return 1;
    if (node_limit > NODES_MAX) return NODES_MAX;
    return int'(node_limit);
  endfunction

  function automatic void queue_edge(input tour_edge_t e);
    pending_edges = {pending_edges, e};
  endfunction

  function automatic void follow_request(input request_t r);
    int             n;
    bit [NODES_MAX-1:0] seen;
    idx_t           here;
    idx_t           pick;
    weight_t        pick_w;
    bit             found;
    if (r.cmd == nnt_pkg::CMD_WRITE) begin
      edge_table[r.from_index][r.to_index] = r.edge_weight;
      return;
    end
    n = active_nodes();
    if (int'(r.start_node) >= n) begin
      queue_edge('{idx_t'(0), idx_t'(0), weight_t'(0), 1'b1, 1'b1});
      return;
    end
    seen = '0;
    seen[r.start_node] = 1'b1;
    here = r.start_node;
    for (int step = 1; step < n; step++) begin
      found  = 1'b0;
      pick   = '0;
      pick_w = '0;
      for (int k = 0; k < n; k++) begin
        if (!seen[k] && (!found || edge_table[here][k] < pick_w)) begin
          found  = 1'b1;
          pick   = idx_t'(k);
          pick_w = edge_table[here][k];
        end
      end
      seen[pick] = 1'b1;
      queue_edge('{here, pick, pick_w, 1'b0, 1'b0});
      here = pick;
    end
    queue_edge('{here, r.start_node, edge_table[here][r.start_node], 1'b0, 1'b1});
  endfunction

  // ---------------------------------------------------------------- helpers
  function automatic weight_t random_weight();
    case ($urandom_range(3))
      0: return weight_t'($urandom_range(3));
      1: return weight_t'($urandom);
      2: return 32'hFFFF_FFFF - weight_t'($urandom_range(2));
      default: return weight_t'($urandom_range(255));
    endcase
  endfunction

  function automatic request_t weight_request(input idx_t f, input idx_t t, input weight_t w);
    return '{nnt_pkg::CMD_WRITE, f, t, w, idx_t'($urandom)};
  endfunction

  function automatic request_t run_request(input idx_t s);
    return '{nnt_pkg::CMD_RUN, idx_t'($urandom), idx_t'($urandom), weight_t'($urandom), s};
  endfunction

  function automatic idx_t pick_index(input int hi);
    if ($urandom_range(3) == 0) return idx_t'($urandom);
    return idx_t'($urandom_range(hi));
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_request(input request_t r);
    if (!steady && $urandom_range(99) < 11) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= r.cmd;
    req_ch.from_index  <= r.from_index;
    req_ch.to_index    <= r.to_index;
    req_ch.edge_weight <= r.edge_weight;
    req_ch.start_node  <= r.start_node;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    follow_request(r);
  endtask

  task automatic drain_tours();
    req_ch.valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(input count_t value);
    drain_tours();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.node_count <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    node_limit = value;
  endtask

  // ---------------------------------------------------------------- result side
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        for (int c = 0; c < HOLD_CYCLES; c++) begin
          rsp_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
      rsp_ch.ready <= steady || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_edges.size() == 0) begin
        report_mismatch($sformatf("unexpected edge %0d->%0d w=%0h bad=%0b last=%0b",
                        rsp_ch.tour_from, rsp_ch.tour_to, rsp_ch.tour_weight,
                        rsp_ch.bad_start, rsp_ch.last));
      end else begin
        due = pending_edges.pop_front();
        if (rsp_ch.tour_from !== due.tour_from)
          report_mismatch($sformatf("tour_from %0d, want %0d", rsp_ch.tour_from, due.tour_from));
        if (rsp_ch.tour_to !== due.tour_to)
          report_mismatch($sformatf("tour_to %0d, want %0d", rsp_ch.tour_to, due.tour_to));
        if (rsp_ch.tour_weight !== due.tour_weight)
          report_mismatch($sformatf("tour_weight %0h, want %0h",
                          rsp_ch.tour_weight, due.tour_weight));
        if (rsp_ch.bad_start !== due.bad_start)
          report_mismatch($sformatf("bad_start %0b, want %0b", rsp_ch.bad_start, due.bad_start));
        if (rsp_ch.last !== due.last)
          report_mismatch($sformatf("last %0b, want %0b", rsp_ch.last, due.last));
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // load the low block of the matrix, then runs over the whole block
  task automatic test_fill_block();
    write_node_count(count_t'(FILL_NODES));
    for (int f = 0; f < FILL_NODES; f++) begin
      for (int t = 0; t < FILL_NODES; t++) begin
        send_request(weight_request(idx_t'(f), idx_t'(t), random_weight()));
      end
    end
    send_request(run_request(idx_t'(0)));
    send_request(run_request(idx_t'(FILL_NODES - 1)));
    send_request(run_request(idx_t'($urandom_range(FILL_NODES - 2, 1))));
  endtask

  // ties, extreme weights, bad start
  task automatic test_small_graph();
    write_node_count(count_t'(4));
    send_request(weight_request(idx_t'(0), idx_t'(1), 32'd5));
    send_request(weight_request(idx_t'(0), idx_t'(2), 32'd5));
    send_request(weight_request(idx_t'(0), idx_t'(3), 32'd5));
    send_request(weight_request(idx_t'(1), idx_t'(0), 32'd0));
    send_request(weight_request(idx_t'(1), idx_t'(2), 32'hFFFF_FFFF));
    send_request(weight_request(idx_t'(1), idx_t'(3), 32'hFFFF_FFFF));
    send_request(weight_request(idx_t'(2), idx_t'(0), 32'd1));
    send_request(weight_request(idx_t'(2), idx_t'(3), 32'h8000_0000));
    send_request(weight_request(idx_t'(3), idx_t'(0), 32'h7FFF_FFFF));
    send_request(weight_request(idx_t'(3), idx_t'(1), 32'd3));
    send_request(weight_request(idx_t'(3), idx_t'(2), 32'd0));
    send_request(weight_request(idx_t'(63), idx_t'(63), 32'hA5A5_5A5A));
    send_request(run_request(idx_t'(0)));
    send_request(run_request(idx_t'(3)));
    send_request(run_request(idx_t'(4)));
    send_request(run_request(idx_t'(63)));
  endtask

  // single node and zero count
  task automatic test_count_extremes();
    write_node_count(count_t'(1));
    send_request(run_request(idx_t'(0)));
    send_request(run_request(idx_t'(1)));
    write_node_count(count_t'(0));
    send_request(run_request(idx_t'(0)));
    send_request(run_request(idx_t'(63)));
  endtask

  task automatic test_random_mix();
    int n;
    int hi;
    for (int phase = 0; phase < 3; phase++) begin
      write_node_count(count_t'($urandom_range(FILL_NODES, 2)));
      steady = (phase == 1);
      n  = active_nodes();
      hi = (n + 1 > 63) ? 63 : n + 1;
      for (int k = 0; k < 16; k++) begin
        if ($urandom_range(9) < 6)
          send_request(weight_request(pick_index(hi), pick_index(hi), random_weight()));
        else if ($urandom_range(7) == 0)
          send_request(run_request(idx_t'($urandom)));
        else
          send_request(run_request(idx_t'($urandom_range(n - 1))));
      end
    end
    steady = 1'b0;
  endtask

  // result side held off while runs keep coming
  task automatic test_result_stall();
    write_node_count(count_t'(FILL_NODES));
    holds_asked++;
    for (int k = 0; k < 5; k++) begin
      send_request(run_request(idx_t'($urandom_range(FILL_NODES - 1))));
    end
    write_node_count(nnt_pkg::COUNT_RESET);
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    req_ch.valid       = 1'b0;
    req_ch.cmd         = nnt_pkg::CMD_WRITE;
    req_ch.from_index  = '0;
    req_ch.to_index    = '0;
    req_ch.edge_weight = '0;
    req_ch.start_node  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.node_count  = nnt_pkg::COUNT_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_block();
    test_small_graph();
    test_count_extremes();
    test_random_mix();
    test_result_stall();
    drain_tours();

    if (mismatches == 0) begin
      $display("nearest_neighbor_tour_top regression: pass");
    end else begin
      $display("nearest_neighbor_tour_top regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("nearest_neighbor_tour_top regression: fail");
    $finish;
  end

endmodule
